// ===== hw/rtl/rbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared constants and types of the retransmit backoff scheduler.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int QUEUE_DEPTH = 64;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_COMPLETED = 3'd1;
    localparam logic [2:0] OP_ABORTED   = 3'd2;
    localparam logic [2:0] OP_REQUEUE   = 3'd3;
    localparam logic [2:0] OP_EXPIRED   = 3'd4;

    localparam logic [1:0] KIND_RETX    = 2'd0;
    localparam logic [1:0] KIND_LIMIT   = 2'd1;
    localparam logic [1:0] KIND_DELETED = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic [0:0] REG_BASE  = 1'd0;
    localparam logic [0:0] REG_LIMIT = 1'd1;

    // Power unit control: start a B^(n) computation.
    typedef struct packed {
        logic        start;
        logic [3:0]  base;
        logic [3:0]  exponent;
    } pow_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } pow_rsp_t;

endpackage : rbs_pkg
`default_nettype wire

// ===== hw/rtl/rbs_pow_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pow_unit
// Saturating 32-bit power B^n, one multiply per cycle.
// ----------------------------------------------------------------------------
module rbs_pow_unit
    import rbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pow_req_t req,
    output pow_rsp_t      rsp
);

    logic        busy_reg;
    logic [3:0]  left_reg;
    logic [3:0]  base_reg;
    logic [31:0] acc_reg;
    logic        done_reg;
    logic [35:0] prod;

    assign prod = {4'd0, acc_reg} * {32'd0, base_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && left_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg  <= 32'd1;
            left_reg <= req.exponent;
            base_reg <= req.base;
        end
        else if (busy_reg && left_reg != 4'd0)
        begin
            // saturate and stop once past 32 bits
            if (prod[35:32] != 4'd0)
            begin
                acc_reg  <= 32'hFFFF_FFFF;
                left_reg <= 4'd0;
            end
            else
            begin
                acc_reg  <= prod[31:0];
                left_reg <= left_reg - 4'd1;
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule : rbs_pow_unit
`default_nettype wire

// ===== hw/rtl/retransmit_backoff_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_backoff_scheduler
// Retransmission table and queue with exponential backoff.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while the sequencer is idle.
// A tick does a queue head read and a compare and, when the head is due, sends
// a result, which waits on out_ready. Completed/aborted walk the table slot
// by slot (read, compare) and stop at the first match. A requeue walks the
// table the same way and decides; for a known key it then runs the power
// unit, one multiply per cycle for up to count-1 multiplies, and writes the
// queue. An expiry walks every queued entry (read, check) and compacts
// survivors in place. Each deleted result is held in the result register
// until the next match or the end of the sweep, so its last flag is known
// when it goes out; every match after the first first sends the held result,
// which waits on out_ready, and then revisits its entry.
// Table key match uses valid bits in flip-flops; payload lives in memories.
// ----------------------------------------------------------------------------
module retransmit_backoff_scheduler
    import rbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op,
    input  wire logic [31:0] now,
    input  wire logic [63:0] bundle_tag,
    input  wire logic [15:0] peer_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [63:0]      out_bundle,
    output logic [15:0]      out_peer,
    output logic             last
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TREAD  = 4'd1;  // issue table read
    localparam logic [3:0] S_TCMP   = 4'd2;  // compare table entry
    localparam logic [3:0] S_RQDEC  = 4'd3;  // requeue decision
    localparam logic [3:0] S_POW    = 4'd4;  // wait for power unit
    localparam logic [3:0] S_PUSH   = 4'd5;
    localparam logic [3:0] S_QREAD  = 4'd6;  // tick: head read
    localparam logic [3:0] S_QCMP   = 4'd7;
    localparam logic [3:0] S_XREAD  = 4'd8;  // expiry: read entry
    localparam logic [3:0] S_XCHK   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10; // hold result until taken
    localparam logic [3:0] S_XEND   = 4'd11;

    localparam int QCNT_W = QIDX_W + 1;
    localparam int TCNT_W = TIDX_W + 1;

    // configuration
    logic [3:0] base_reg;
    logic [3:0] limit_reg;

    // captured request
    logic [2:0]  op_reg;
    logic [31:0] now_reg;
    logic [63:0] tag_reg;
    logic [15:0] peer_reg;

    logic [3:0] state_reg, state_next;

    // table
    logic [TABLE_DEPTH-1:0] tvalid_reg;
    logic [63:0] tbundle_mem [TABLE_DEPTH];
    logic [15:0] tpeer_mem   [TABLE_DEPTH];
    logic [3:0]  tcount_mem  [TABLE_DEPTH];
    logic [63:0] tb_rd;
    logic [15:0] tp_rd;
    logic [3:0]  tc_rd;
    logic [TCNT_W-1:0] tidx_reg;
    logic [TIDX_W-1:0] hit_reg;
    logic              hit_found_reg;
    logic [TIDX_W-1:0] free_idx;
    logic              free_any;

    // queue
    logic [63:0] qbundle_mem [QUEUE_DEPTH];
    logic [15:0] qpeer_mem   [QUEUE_DEPTH];
    logic [31:0] qdue_mem    [QUEUE_DEPTH];
    logic [63:0] qb_rd;
    logic [15:0] qp_rd;
    logic [31:0] qd_rd;
    logic [QIDX_W-1:0] head_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] scan_reg;   // entries examined
    logic [QCNT_W-1:0] kept_reg;   // survivors written back
    logic [QCNT_W-1:0] total_reg;
    logic              emitted_reg; // a deleted result waits in the result register

    // queue write port
    logic              qwe;
    logic [QIDX_W-1:0] qwaddr;
    logic [63:0]       qwb;
    logic [15:0]       qwp;
    logic [31:0]       qwd;
    logic [QIDX_W-1:0] qraddr;

    // result register
    logic [1:0]  kind_reg;
    logic [63:0] ob_reg;
    logic [15:0] op_peer_reg;
    logic        last_reg;
    logic [3:0]  ret_state_reg;  // where to go after result taken

    logic [3:0]  cnt_reg;        // new count for requeue
    logic [31:0] due_reg;

    pow_req_t pow_req;
    pow_rsp_t pow_rsp;

    rbs_pow_unit u_pow (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pow_req),
        .rsp   (pow_rsp)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign kind       = kind_reg;
    assign out_bundle = ob_reg;
    assign out_peer   = op_peer_reg;
    assign last       = last_reg;

    // lowest free table slot (priority over valid flops)
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!tvalid_reg[i])
            begin
                free_idx = TIDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // table read port
    always_ff @(posedge clk)
    begin
        tb_rd <= tbundle_mem[tidx_reg[TIDX_W-1:0]];
        tp_rd <= tpeer_mem[tidx_reg[TIDX_W-1:0]];
        tc_rd <= tcount_mem[tidx_reg[TIDX_W-1:0]];
    end

    // queue memory
    always_comb
    begin
        if (op_reg == OP_EXPIRED)
            qraddr = QIDX_W'({1'b0, head_reg} + scan_reg);
        else
            qraddr = head_reg;
    end

    always_ff @(posedge clk)
    begin
        if (qwe)
        begin
            qbundle_mem[qwaddr] <= qwb;
            qpeer_mem[qwaddr]   <= qwp;
            qdue_mem[qwaddr]    <= qwd;
        end
        qb_rd <= qbundle_mem[qraddr];
        qp_rd <= qpeer_mem[qraddr];
        qd_rd <= qdue_mem[qraddr];
    end

    always_comb
    begin
        qwe    = 1'b0;
        qwaddr = QIDX_W'({1'b0, head_reg} + fill_reg);
        qwb    = tag_reg;
        qwp    = peer_reg;
        qwd    = due_reg;
        if (state_reg == S_PUSH)
            qwe = 1'b1;
        else if (state_reg == S_XCHK && qb_rd != tag_reg)
        begin
            // compact survivor down to the kept position
            qwe    = 1'b1;
            qwaddr = QIDX_W'({1'b0, head_reg} + kept_reg);
            qwb    = qb_rd;
            qwp    = qp_rd;
            qwd    = qd_rd;
        end
    end

    always_comb
    begin
        pow_req.start    = (state_reg == S_RQDEC) && hit_found_reg
                           && !(({1'b0, tc_rd} + 5'd1) > {1'b0, limit_reg})
                           && (fill_reg < QCNT_W'(QUEUE_DEPTH));
        pow_req.base     = base_reg;
        pow_req.exponent = tc_rd;   // count-1 of the new count
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    case (op)
                        OP_TICK:      state_next = S_QREAD;
                        OP_COMPLETED,
                        OP_ABORTED,
                        OP_REQUEUE:   state_next = S_TREAD;
                        OP_EXPIRED:   state_next = S_XREAD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            S_TREAD: state_next = S_TCMP;
            S_TCMP:
                if (tvalid_reg[tidx_reg[TIDX_W-1:0]] && tb_rd == tag_reg
                    && tp_rd == peer_reg)
                    state_next = (op_reg == OP_REQUEUE) ? S_RQDEC : S_IDLE;
                else if (tidx_reg == TCNT_W'(TABLE_DEPTH - 1))
                    state_next = (op_reg == OP_REQUEUE) ? S_RQDEC : S_IDLE;
                else
                    state_next = S_TREAD;
            S_RQDEC:
                if (pow_req.start)
                    state_next = S_POW;
                else if (!hit_found_reg && free_any
                         && fill_reg < QCNT_W'(QUEUE_DEPTH))
                    state_next = S_PUSH;
                else
                    state_next = S_OUT;
            S_POW:   if (pow_rsp.done) state_next = S_PUSH;
            S_PUSH:  state_next = S_IDLE;
            S_QREAD: state_next = S_QCMP;
            S_QCMP:
                state_next = (fill_reg != '0 && qd_rd <= now_reg) ? S_OUT : S_IDLE;
            S_XREAD:
                if (scan_reg == total_reg)
                    state_next = emitted_reg ? S_OUT : S_XEND;
                else
                    state_next = S_XCHK;
            S_XCHK:
                // a second match releases the held result first
                state_next = (qb_rd == tag_reg && emitted_reg) ? S_OUT : S_XREAD;
            S_OUT:
                if (out_ready) state_next = ret_state_reg;
            S_XEND:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= 4'd2;
            limit_reg     <= 4'd8;
            tvalid_reg    <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            op_reg        <= OP_TICK;
            tidx_reg      <= '0;
            hit_reg       <= '0;
            scan_reg      <= '0;
            kept_reg      <= '0;
            total_reg     <= '0;
            hit_found_reg <= 1'b0;
            emitted_reg   <= 1'b0;
            ret_state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE:  base_reg  <= cfg_data;
                    REG_LIMIT: limit_reg <= cfg_data;
                    default:   ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        op_reg        <= op;
                        tidx_reg      <= '0;
                        scan_reg      <= '0;
                        kept_reg      <= '0;
                        total_reg     <= fill_reg;
                        hit_found_reg <= 1'b0;
                        emitted_reg   <= 1'b0;
                    end
                S_TCMP:
                    if (tvalid_reg[tidx_reg[TIDX_W-1:0]] && tb_rd == tag_reg
                        && tp_rd == peer_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_reg       <= tidx_reg[TIDX_W-1:0];
                        // drop the key on completed / aborted
                        if (op_reg != OP_REQUEUE)
                            tvalid_reg[tidx_reg[TIDX_W-1:0]] <= 1'b0;
                    end
                    else
                        tidx_reg <= tidx_reg + TCNT_W'(1);
                S_RQDEC:
                begin
                    ret_state_reg <= S_IDLE;
                    if (hit_found_reg && ({1'b0, tc_rd} + 5'd1) > {1'b0, limit_reg})
                        tvalid_reg[hit_reg] <= 1'b0;
                    else if (!hit_found_reg && free_any
                             && fill_reg < QCNT_W'(QUEUE_DEPTH))
                    begin
                        tvalid_reg[free_idx] <= 1'b1;
                        hit_reg              <= free_idx;
                    end
                end
                S_PUSH:  fill_reg <= fill_reg + QCNT_W'(1);
                S_QCMP:
                    if (fill_reg != '0 && qd_rd <= now_reg)
                    begin
                        head_reg      <= head_reg + QIDX_W'(1);
                        fill_reg      <= fill_reg - QCNT_W'(1);
                        ret_state_reg <= S_IDLE;
                    end
                S_XREAD:
                    if (scan_reg == total_reg)
                    begin
                        fill_reg      <= kept_reg;
                        emitted_reg   <= 1'b0;
                        ret_state_reg <= S_IDLE;
                    end
                S_XCHK:
                    if (qb_rd != tag_reg)
                    begin
                        scan_reg <= scan_reg + QCNT_W'(1);
                        kept_reg <= kept_reg + QCNT_W'(1);
                    end
                    else if (emitted_reg)
                    begin
                        // send the held result, then revisit this entry
                        emitted_reg   <= 1'b0;
                        ret_state_reg <= S_XCHK;
                    end
                    else
                    begin
                        emitted_reg <= 1'b1;
                        scan_reg    <= scan_reg + QCNT_W'(1);
                    end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            now_reg  <= now;
            tag_reg  <= bundle_tag;
            peer_reg <= peer_id;
        end
        if (state_reg == S_RQDEC)
        begin
            cnt_reg     <= tc_rd + 4'd1;
            ob_reg      <= tag_reg;
            op_peer_reg <= peer_reg;
            last_reg    <= 1'b1;
            kind_reg    <= (hit_found_reg && ({1'b0, tc_rd} + 5'd1) > {1'b0, limit_reg})
                           ? KIND_LIMIT : KIND_FULL;
            if (!hit_found_reg)
            begin
                cnt_reg <= 4'd1;
                due_reg <= (now_reg == 32'hFFFF_FFFF) ? now_reg : now_reg + 32'd1;
            end
        end
        if (state_reg == S_POW && pow_rsp.done)
        begin
            due_reg <= ({1'b0, now_reg} + {1'b0, pow_rsp.value} > 33'h0_FFFF_FFFF)
                       ? 32'hFFFF_FFFF : now_reg + pow_rsp.value;
        end
        if (state_reg == S_PUSH)
        begin
            tcount_mem[hit_reg]  <= cnt_reg;
            tbundle_mem[hit_reg] <= tag_reg;
            tpeer_mem[hit_reg]   <= peer_reg;
        end
        if (state_reg == S_QCMP)
        begin
            kind_reg    <= KIND_RETX;
            ob_reg      <= qb_rd;
            op_peer_reg <= qp_rd;
            last_reg    <= 1'b1;
        end
        // hold a deleted entry; it goes out on the next match or at sweep end
        if (state_reg == S_XCHK && qb_rd == tag_reg && !emitted_reg)
        begin
            kind_reg    <= KIND_DELETED;
            ob_reg      <= qb_rd;
            op_peer_reg <= qp_rd;
            last_reg    <= 1'b0;
        end
        if (state_reg == S_XREAD && scan_reg == total_reg)
            last_reg <= 1'b1;
    end

    // Assertions
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while result pending");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overfill");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH |-> fill_reg < QCNT_W'(QUEUE_DEPTH))
        else $error("push into full queue");

endmodule : retransmit_backoff_scheduler
`default_nettype wire
